@@ sv/psw_pkg.sv @@
// ----------------------------------------------------------------------------
// psw_pkg: shared types and constants for the progress stall watchdog
// Register indexes, reset values and the control/flag structs.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_REPEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_IDLE    = 2'd2;

  // Reset values of the thresholds (ms)
  localparam logic [CFG_W-1:0] STALL_FIRST_RST  = 32'd5000;
  localparam logic [CFG_W-1:0] STALL_REPEAT_RST = 32'd30000;
  localparam logic [CFG_W-1:0] DRAW_IDLE_RST    = 32'd10000;

  // Single-bit watchdog state
  typedef struct packed {
    logic outstanding;  // stall report issued and not yet cleared
    logic logged;       // draw-idle already reported for this packet count
    logic seeded;       // first poll has been seen
  } psw_ctl_t;

  // Per-poll report flags
  typedef struct packed {
    logic inventory_request;
    logic draw_idle_report;
    logic stall_cleared;
    logic stall_first;
    logic stall_report;
  } psw_flags_t;

endpackage

@@ sv/psw_eval.sv @@
// ----------------------------------------------------------------------------
// psw_eval: one-poll watchdog evaluation
// Combinational next-state and report logic for one registered poll.
// ----------------------------------------------------------------------------
module psw_eval import psw_pkg::*; #(
  parameter int unsigned TW = 32
) (
  input  logic [TW-1:0]    now,
  input  logic [TW-1:0]    last,
  input  logic [31:0]      pkts,
  input  logic             past_first,
  input  logic [CFG_W-1:0] stall_first_ms,
  input  logic [CFG_W-1:0] stall_repeat_ms,
  input  logic [CFG_W-1:0] draw_idle_ms,
  input  psw_ctl_t         ctl,
  input  logic [TW-1:0]    reported_at,
  input  logic [31:0]      seen_pkts,
  input  logic [TW-1:0]    change_time,
  output psw_ctl_t         ctl_nxt,
  output logic [TW-1:0]    reported_at_nxt,
  output logic [31:0]      seen_pkts_nxt,
  output logic [TW-1:0]    change_time_nxt,
  output psw_flags_t       flags,
  output logic [TW-1:0]    since,
  output logic [TW-1:0]    idle_for
);

  logic [31:0]   seen_eff;
  logic [TW-1:0] chg_eff;
  logic [TW-1:0] rep_diff;
  logic [TW-1:0] idle_diff;
  logic          stall_hit;
  logic          fire;
  logic          pkt_chg;
  logic          idle_fire;

  always_comb begin
    // first poll seeds the packet tracker with its own values
    seen_eff  = ctl.seeded ? seen_pkts   : pkts;
    chg_eff   = ctl.seeded ? change_time : now;

    since     = (now > last) ? (now - last) : '0;
    stall_hit = 32'(since) >= stall_first_ms;
    rep_diff  = now - reported_at;
    fire      = stall_hit && (!ctl.outstanding || 32'(rep_diff) >= stall_repeat_ms);

    pkt_chg   = pkts != seen_eff;
    idle_diff = now - chg_eff;
    idle_fire = !pkt_chg && !ctl.logged && !stall_hit && past_first &&
                32'(idle_diff) >= draw_idle_ms;

    ctl_nxt.seeded      = 1'b1;
    ctl_nxt.outstanding = stall_hit ? (ctl.outstanding | fire) : 1'b0;
    ctl_nxt.logged      = pkt_chg ? 1'b0 : (ctl.logged | idle_fire);
    reported_at_nxt     = fire ? now : reported_at;
    seen_pkts_nxt       = pkts;
    change_time_nxt     = pkt_chg ? now : chg_eff;
    idle_for            = now - change_time_nxt;

    flags.stall_report      = fire;
    flags.stall_first       = fire && !ctl.outstanding;
    flags.stall_cleared     = !stall_hit && ctl.outstanding;
    flags.draw_idle_report  = idle_fire;
    flags.inventory_request = fire | idle_fire;
  end

endmodule

@@ sv/progress_stall_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// progress_stall_watchdog_unit: progress watchdog with repeated stall report
// Polls arrive on a stream; each poll yields one report item.
// ----------------------------------------------------------------------------
// Each accepted poll produces exactly one result item two register stages
// later: the poll is captured in an input register, evaluated against the
// watchdog state in one pass of short logic (a few TIME_BITS-wide subtracts
// and 32-bit compares), and the result lands in the output register while the
// state updates in the same cycle. Throughput is one poll per clock; the only
// thing that slows it is back-pressure on the output, which holds the output
// register and then the input register. Time arithmetic is modulo
// 2^min(TIME_BITS,32); the packet count is always compared at 32 bits.
// Thresholds are to be written via cfg_we/cfg_index/cfg_data while the block
// is idle (not enforced by the block itself); unknown indexes are ignored.
// ----------------------------------------------------------------------------
module progress_stall_watchdog_unit import psw_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // poll stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,  // now_ms, last_field_ms, packet_count
  input  logic                 in_tuser,  // past_first_field
  // report stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata, // since_field_ms, draw_idle_for_ms
  output logic [4:0]           out_tuser, // stall_report, stall_first,
                                          // stall_cleared, draw_idle_report,
                                          // inventory_request
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // effective time width: fields are 32 bits, narrower if TIME_BITS says so
  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  // thresholds
  logic [CFG_W-1:0] stall_first_r, stall_repeat_r, draw_idle_r;

  // input register
  logic          s1_valid_r;
  logic [TW-1:0] s1_now_r, s1_last_r;
  logic [31:0]   s1_pkts_r;
  logic          s1_past_r;

  // watchdog state
  psw_ctl_t      ctl_r, ctl_nxt;
  logic [TW-1:0] reported_at_r, reported_at_nxt;
  logic [31:0]   seen_pkts_r, seen_pkts_nxt;
  logic [TW-1:0] change_time_r, change_time_nxt;

  // output register
  logic          out_valid_r;
  psw_flags_t    out_flags_r, flags;
  logic [TW-1:0] out_since_r, since;
  logic [TW-1:0] out_idle_r, idle_for;

  logic advance;

  // the registered poll moves on when the output slot is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_first_r  <= STALL_FIRST_RST;
      stall_repeat_r <= STALL_REPEAT_RST;
      draw_idle_r    <= DRAW_IDLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STALL_FIRST:  stall_first_r  <= cfg_data;
        CFG_STALL_REPEAT: stall_repeat_r <= cfg_data;
        CFG_DRAW_IDLE:    draw_idle_r    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_now_r  <= in_tdata[TW-1:0];
      s1_last_r <= in_tdata[32 +: TW];
      s1_pkts_r <= in_tdata[95:64];
      s1_past_r <= in_tuser;
    end
  end

  psw_eval #(
    .TW (TW)
  ) u_eval (
    .now             (s1_now_r),
    .last            (s1_last_r),
    .pkts            (s1_pkts_r),
    .past_first      (s1_past_r),
    .stall_first_ms  (stall_first_r),
    .stall_repeat_ms (stall_repeat_r),
    .draw_idle_ms    (draw_idle_r),
    .ctl             (ctl_r),
    .reported_at     (reported_at_r),
    .seen_pkts       (seen_pkts_r),
    .change_time     (change_time_r),
    .ctl_nxt         (ctl_nxt),
    .reported_at_nxt (reported_at_nxt),
    .seen_pkts_nxt   (seen_pkts_nxt),
    .change_time_nxt (change_time_nxt),
    .flags           (flags),
    .since           (since),
    .idle_for        (idle_for)
  );

  // state commits with the result, so the next poll sees it immediately
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r         <= '0;
      reported_at_r <= '0;
      seen_pkts_r   <= '0;
      change_time_r <= '0;
    end else if (advance) begin
      ctl_r         <= ctl_nxt;
      reported_at_r <= reported_at_nxt;
      seen_pkts_r   <= seen_pkts_nxt;
      change_time_r <= change_time_nxt;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags_r <= flags;
      out_since_r <= since;
      out_idle_r  <= idle_for;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {32'(out_idle_r), 32'(out_since_r)};
  assign out_tuser  = out_flags_r;

`ifndef SYNTHESIS
  // first-of-stall only ever rides on a stall report
  a_first_has_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.stall_first |-> out_flags_r.stall_report)
    else $error("stall_first without stall_report");

  // a poll cannot both report a stall and clear it
  a_report_xor_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_flags_r.stall_report && out_flags_r.stall_cleared))
    else $error("stall report and clear in one poll");

  // draw-idle needs fields advancing, so never alongside a stall report
  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.draw_idle_report |-> !out_flags_r.stall_report)
    else $error("draw-idle report during a stall");

  // a stall report leaves a report outstanding for the next poll
  a_report_sets_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
    advance && flags.stall_report |=> ctl_r.outstanding)
    else $error("stall report did not mark outstanding");
`endif

endmodule
